@@ src/cfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfrc_pkg
// Shared types, constants and helpers of the friction impulse clamp pipeline.
// ----------------------------------------------------------------------------
package cfrc_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [1:0] REG_CONTACT_COUNT = 2'd1;

  localparam logic [15:0] TIME_STEP_RST = 16'd1092;

  // Divider and root unit geometry
  localparam int DEN_W    = 32;  // divisor / remainder width
  localparam int QUOT_W   = 31;  // quotient bits, result is known to stay below 2^31
  localparam int ROOT_IN_W = 64; // radicand width
  localparam int DIV_SPS  = 4;   // divider steps per register stage
  localparam int SQRT_SPS = 4;   // root steps per register stage

  // Per-contact data that rides along the whole pipe
  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0][15:0] tan1;
    logic [2:0][15:0] tan2;
    logic [31:0]      minv;
    logic             last;
  } cfrc_item_t;

  // Sideband through the impulse divider
  typedef struct packed {
    cfrc_item_t  item;
    logic [30:0] maxi;
    logic [1:0]  neg;
    logic [1:0]  sat;
  } cfrc_qa_t;

  // Sideband through the root unit
  typedef struct packed {
    cfrc_item_t       item;
    logic [30:0]      maxi;
    logic [1:0][31:0] mag;
    logic [1:0]       neg;
    logic             slip;
  } cfrc_rt_t;

  // Sideband through the rescale divider
  typedef struct packed {
    cfrc_item_t       item;
    logic [1:0][31:0] mag;
    logic [1:0]       neg;
    logic             slip;
  } cfrc_qb_t;

  function automatic logic signed [47:0] smul_32x16(input logic signed [31:0] a,
                                                    input logic signed [15:0] b);
    return a * b;
  endfunction

  function automatic logic signed [48:0] smul_33x16(input logic signed [32:0] a,
                                                    input logic signed [15:0] b);
    return a * b;
  endfunction

endpackage

@@ src/coulomb_friction_impulse_clamp_unit.sv @@
// ----------------------------------------------------------------------------
// coulomb_friction_impulse_clamp_unit
// Tangent friction impulse per particle contact, clamped to the Coulomb cone,
// applied to the particle velocity. Q16.16 / Q2.14 fixed point, saturating.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | beat contents
//  --------+-----+----------------------+------------------------------------
//  in_     | in  | in_valid / in_ready  | velocity, inverse mass, tangents,
//          |     |                      | normal force, friction coefficient
//  out_    | out | out_valid/out_ready  | new velocity, slipping, last_contact
//  cfg_    | in  | cfg_we (no wait)     | time_step, contact_count
//
//  One beat per cycle sustained while out_ready stays high. The pipe holds 11
//  stages of arithmetic plus two dividers of ceil(31/DIV_SPS) stages each and a
//  root unit of ceil(32/SQRT_SPS) stages, 8 each at the defaults.
//  Reset (rst_n low, synchronous) empties the pipe and loads register defaults.
//  Every stage holds while its successor is full, so bubbles close up and a
//  waiting result never blocks new beats until the pipe is full.

module coulomb_friction_impulse_clamp_unit
  import cfrc_pkg::*;
#(
  parameter int DIV_STEPS  = DIV_SPS,
  parameter int SQRT_STEPS = SQRT_SPS
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // contact beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [31:0]        in_inverse_mass,
  input  logic signed [15:0] in_tan1_x,
  input  logic signed [15:0] in_tan1_y,
  input  logic signed [15:0] in_tan1_z,
  input  logic signed [15:0] in_tan2_x,
  input  logic signed [15:0] in_tan2_y,
  input  logic signed [15:0] in_tan2_z,
  input  logic [31:0]        in_normal_force,
  input  logic [15:0]        in_friction_coeff,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  output logic               out_slipping,
  output logic               out_last_contact
);

  // --------------------------------------------------------------------------
  // Configuration and pass counter
  // --------------------------------------------------------------------------
  logic [15:0] ts_r;
  logic [15:0] cc_r;
  logic [15:0] idx_r;
  logic [15:0] idx_nxt;
  logic        last_in;
  logic        in_acc;
  logic [16:0] idx_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TIME_STEP_RST;
      cc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:     ts_r <= cfg_data;
        REG_CONTACT_COUNT: cc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_acc  = in_valid && in_ready;
  assign idx_inc = {1'b0, idx_r} + 17'd1;
  assign last_in = (cc_r != '0) && (idx_inc >= {1'b0, cc_r});
  assign idx_nxt = last_in ? '0 : idx_inc[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (in_acc) idx_r <= idx_nxt;
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when empty or when its successor moves
  // --------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic r0, r1, r2, r3, r4, r5, r6, r7, r8, r9, r10;
  logic qa_in_rdy, qa_v, rt_in_rdy, rt_v, qb_in_rdy, qb_v;

  assign r10 = !v10_r || out_ready;
  assign r9  = !v9_r  || r10;
  assign r8  = !v8_r  || r9;
  assign r7  = !v7_r  || r8;
  assign r6  = !v6_r  || qb_in_rdy;
  assign r5  = !v5_r  || rt_in_rdy;
  assign r4  = !v4_r  || r5;
  assign r3  = !v3_r  || r4;
  assign r2  = !v2_r  || qa_in_rdy;
  assign r1  = !v1_r  || r2;
  assign r0  = !v0_r  || r1;
  assign in_ready = r0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r} <= '0;
    end else begin
      if (r0)  v0_r  <= in_valid;
      if (r1)  v1_r  <= v0_r;
      if (r2)  v2_r  <= v1_r;
      if (r3)  v3_r  <= qa_v;
      if (r4)  v4_r  <= v3_r;
      if (r5)  v5_r  <= v4_r;
      if (r6)  v6_r  <= rt_v;
      if (r7)  v7_r  <= qb_v;
      if (r8)  v8_r  <= v7_r;
      if (r9)  v9_r  <= v8_r;
      if (r10) v10_r <= v9_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: tangent dot products, dt * normal force
  // --------------------------------------------------------------------------
  cfrc_item_t           it_in, it0_r;
  logic [1:0][2:0][47:0] dot_nxt, dot_r;
  logic [31:0]          tn_r;
  logic [15:0]          mu_r;
  logic [47:0]          tnp;

  always_comb begin
    it_in.vel  = {in_vel_z, in_vel_y, in_vel_x};
    it_in.tan1 = {in_tan1_z, in_tan1_y, in_tan1_x};
    it_in.tan2 = {in_tan2_z, in_tan2_y, in_tan2_x};
    it_in.minv = in_inverse_mass;
    it_in.last = last_in;
    for (int a = 0; a < 3; a++) begin
      dot_nxt[0][a] = smul_32x16(it_in.vel[a], it_in.tan1[a]);
      dot_nxt[1][a] = smul_32x16(it_in.vel[a], it_in.tan2[a]);
    end
    tnp = ts_r * in_normal_force;
  end

  always_ff @(posedge clk) begin
    if (r0) begin
      it0_r <= it_in;
      dot_r <= dot_nxt;
      tn_r  <= tnp[47:16];
      mu_r  <= in_friction_coeff;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: tangent speeds (magnitude and sign), impulse limit
  // --------------------------------------------------------------------------
  cfrc_item_t       it1_r;
  logic [1:0][33:0] cm_nxt, cm1_r;
  logic [1:0]       pos_nxt, pos1_r;
  logic [30:0]      maxi_nxt, maxi1_r;
  logic [47:0]      lim_p;

  always_comb begin
    logic [49:0] su;
    logic [49:0] am;
    su = '0;
    am = '0;
    for (int i = 0; i < 2; i++) begin
      su = {{2{dot_r[i][0][47]}}, dot_r[i][0]} + {{2{dot_r[i][1][47]}}, dot_r[i][1]}
         + {{2{dot_r[i][2][47]}}, dot_r[i][2]};
      am = su[49] ? (~su + 50'd1) : su;
      cm_nxt[i]  = am[47:14];
      pos_nxt[i] = !su[49] && (am[49:14] != '0);
    end
    lim_p    = tn_r * mu_r;
    maxi_nxt = (lim_p[47:45] != '0) ? '1 : lim_p[44:14];
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      it1_r   <= it0_r;
      cm1_r   <= cm_nxt;
      pos1_r  <= pos_nxt;
      maxi1_r <= maxi_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divider operands, saturation check (quotient >= 2^31)
  // --------------------------------------------------------------------------
  cfrc_qa_t         qa_nxt, qa2_r, qa_o;
  logic [1:0][31:0] rem_nxt, rem2_r;
  logic [1:0][30:0] lo_nxt, lo2_r;
  logic [1:0][30:0] qa_q;

  always_comb begin
    qa_nxt.item = it1_r;
    qa_nxt.maxi = maxi1_r;
    qa_nxt.neg  = pos1_r;
    for (int i = 0; i < 2; i++) begin
      rem_nxt[i]    = {13'd0, cm1_r[i][33:15]};
      lo_nxt[i]     = {cm1_r[i][14:0], 16'd0};
      qa_nxt.sat[i] = rem_nxt[i] >= it1_r.minv;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      qa2_r  <= qa_nxt;
      rem2_r <= rem_nxt;
      lo2_r  <= lo_nxt;
    end
  end

  cfrc_div #(
    .DW     (DEN_W),
    .QW     (QUOT_W),
    .SPS    (DIV_STEPS),
    .SIDE_W ($bits(cfrc_qa_t))
  ) u_div_imp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (qa_in_rdy),
    .in_den    (qa2_r.item.minv),
    .in_rem    (rem2_r),
    .in_lo     (lo2_r),
    .in_side   (qa2_r),
    .out_valid (qa_v),
    .out_ready (r3),
    .out_quot  (qa_q),
    .out_side  (qa_o)
  );

  // --------------------------------------------------------------------------
  // Stage 3: impulse magnitudes (static particle gives zero)
  // --------------------------------------------------------------------------
  cfrc_item_t       it3_r;
  logic [30:0]      maxi3_r;
  logic [1:0][31:0] mag_nxt, mag3_r;
  logic [1:0]       neg3_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (qa_o.item.minv == '0) mag_nxt[i] = '0;
      else if (qa_o.sat[i]) mag_nxt[i] = qa_o.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else mag_nxt[i] = {1'b0, qa_q[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      it3_r   <= qa_o.item;
      maxi3_r <= qa_o.maxi;
      mag3_r  <= mag_nxt;
      neg3_r  <= qa_o.neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squares for the cone test
  // --------------------------------------------------------------------------
  cfrc_item_t       it4_r;
  logic [30:0]      maxi4_r;
  logic [1:0][31:0] mag4_r;
  logic [1:0]       neg4_r;
  logic [1:0][63:0] sq_nxt, sq4_r;
  logic [61:0]      mm_nxt, mm4_r;

  always_comb begin
    for (int i = 0; i < 2; i++) sq_nxt[i] = mag3_r[i] * mag3_r[i];
    mm_nxt = maxi3_r * maxi3_r;
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      it4_r   <= it3_r;
      maxi4_r <= maxi3_r;
      mag4_r  <= mag3_r;
      neg4_r  <= neg3_r;
      sq4_r   <= sq_nxt;
      mm4_r   <= mm_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: squared length, slip decision
  // --------------------------------------------------------------------------
  cfrc_rt_t    rt_nxt, rt5_r, rt_o;
  logic [63:0] sum_nxt, sum5_r;
  logic [31:0] root;

  always_comb begin
    sum_nxt     = sq4_r[0] + sq4_r[1];
    rt_nxt.item = it4_r;
    rt_nxt.maxi = maxi4_r;
    rt_nxt.mag  = mag4_r;
    rt_nxt.neg  = neg4_r;
    rt_nxt.slip = sum_nxt > {2'b00, mm4_r};
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      rt5_r  <= rt_nxt;
      sum5_r <= sum_nxt;
    end
  end

  cfrc_sqrt #(
    .XW     (ROOT_IN_W),
    .SPS    (SQRT_STEPS),
    .SIDE_W ($bits(cfrc_rt_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_ready  (rt_in_rdy),
    .in_x      (sum5_r),
    .in_side   (rt5_r),
    .out_valid (rt_v),
    .out_ready (r6),
    .out_root  (root),
    .out_side  (rt_o)
  );

  // --------------------------------------------------------------------------
  // Stage 6: impulse * limit, rescale divider operands
  // --------------------------------------------------------------------------
  cfrc_qb_t         qb_nxt, qb6_r, qb_o;
  logic [1:0][61:0] prod_nxt, prod6_r;
  logic [31:0]      len6_r;
  logic [1:0][31:0] rem_b;
  logic [1:0][30:0] lo_b;
  logic [1:0][30:0] qb_q;

  always_comb begin
    logic [62:0] pr;
    pr = '0;
    for (int i = 0; i < 2; i++) begin
      pr          = rt_o.mag[i] * rt_o.maxi;
      prod_nxt[i] = pr[61:0];
    end
    qb_nxt.item = rt_o.item;
    qb_nxt.mag  = rt_o.mag;
    qb_nxt.neg  = rt_o.neg;
    qb_nxt.slip = rt_o.slip;
  end

  always_ff @(posedge clk) begin
    if (r6) begin
      qb6_r   <= qb_nxt;
      prod6_r <= prod_nxt;
      len6_r  <= root;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_b[i] = {1'b0, prod6_r[i][61:31]};
      lo_b[i]  = prod6_r[i][30:0];
    end
  end

  cfrc_div #(
    .DW     (DEN_W),
    .QW     (QUOT_W),
    .SPS    (DIV_STEPS),
    .SIDE_W ($bits(cfrc_qb_t))
  ) u_div_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v6_r),
    .in_ready  (qb_in_rdy),
    .in_den    (len6_r),
    .in_rem    (rem_b),
    .in_lo     (lo_b),
    .in_side   (qb6_r),
    .out_valid (qb_v),
    .out_ready (r7),
    .out_quot  (qb_q),
    .out_side  (qb_o)
  );

  // --------------------------------------------------------------------------
  // Stage 7: final signed impulses times tangents
  // --------------------------------------------------------------------------
  cfrc_item_t       it7_r;
  logic             slip7_r;
  logic [2:0][48:0] pa_nxt, pa7_r, pb_nxt, pb7_r;

  always_comb begin
    logic [31:0]      fm;
    logic [1:0][32:0] sv;
    fm = '0;
    for (int i = 0; i < 2; i++) begin
      fm    = qb_o.slip ? {1'b0, qb_q[i]} : qb_o.mag[i];
      sv[i] = qb_o.neg[i] ? (~{1'b0, fm} + 33'd1) : {1'b0, fm};
    end
    for (int a = 0; a < 3; a++) begin
      pa_nxt[a] = smul_33x16(sv[0], qb_o.item.tan1[a]);
      pb_nxt[a] = smul_33x16(sv[1], qb_o.item.tan2[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (r7) begin
      it7_r   <= qb_o.item;
      slip7_r <= qb_o.slip;
      pa7_r   <= pa_nxt;
      pb7_r   <= pb_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: world impulse per axis, truncated and saturated
  // --------------------------------------------------------------------------
  cfrc_item_t       it8_r;
  logic             slip8_r;
  logic [2:0][31:0] pm_nxt, pm8_r;
  logic [2:0]       pn_nxt, pn8_r;

  always_comb begin
    logic [49:0] su;
    logic [49:0] am;
    logic [35:0] m;
    su = '0;
    am = '0;
    m  = '0;
    for (int a = 0; a < 3; a++) begin
      su = {pa7_r[a][48], pa7_r[a]} + {pb7_r[a][48], pb7_r[a]};
      am = su[49] ? (~su + 50'd1) : su;
      m  = am[49:14];
      pn_nxt[a] = su[49];
      if (su[49]) pm_nxt[a] = (m > 36'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
      else        pm_nxt[a] = (m > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r8) begin
      it8_r   <= it7_r;
      slip8_r <= slip7_r;
      pm8_r   <= pm_nxt;
      pn8_r   <= pn_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: velocity change magnitude
  // --------------------------------------------------------------------------
  cfrc_item_t       it9_r;
  logic             slip9_r;
  logic [2:0][47:0] dvm_nxt, dvm9_r;
  logic [2:0]       dn9_r;

  always_comb begin
    logic [63:0] pp;
    pp = '0;
    for (int a = 0; a < 3; a++) begin
      pp         = it8_r.minv * pm8_r[a];
      dvm_nxt[a] = pp[63:16];
    end
  end

  always_ff @(posedge clk) begin
    if (r9) begin
      it9_r   <= it8_r;
      slip9_r <= slip8_r;
      dvm9_r  <= dvm_nxt;
      dn9_r   <= pn8_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: saturated velocity update, output register
  // --------------------------------------------------------------------------
  logic [2:0][31:0] nv_nxt, nv10_r;
  logic             slip10_r;
  logic             last10_r;

  always_comb begin
    logic [49:0] dv;
    logic [49:0] s;
    dv = '0;
    s  = '0;
    for (int a = 0; a < 3; a++) begin
      dv = dn9_r[a] ? (~{2'b00, dvm9_r[a]} + 50'd1) : {2'b00, dvm9_r[a]};
      s  = {{18{it9_r.vel[a][31]}}, it9_r.vel[a]} + dv;
      if (!s[49] && (s[48:31] != '0))     nv_nxt[a] = 32'h7FFF_FFFF;
      else if (s[49] && (s[48:31] != '1)) nv_nxt[a] = 32'h8000_0000;
      else                                nv_nxt[a] = s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r10) begin
      nv10_r   <= nv_nxt;
      slip10_r <= slip9_r;
      last10_r <= it9_r.last;
    end
  end

  assign out_valid        = v10_r;
  assign out_new_vel_x    = nv10_r[0];
  assign out_new_vel_y    = nv10_r[1];
  assign out_new_vel_z    = nv10_r[2];
  assign out_slipping     = slip10_r;
  assign out_last_contact = last10_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // static particle never gets an impulse out of the divider stage
  a_static_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (it3_r.minv == '0) |-> (mag3_r == '0))
    else $error("nonzero impulse on static particle");

  // a slipping contact always has a nonzero length from the root unit
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r && qb6_r.slip |-> (len6_r != '0))
    else $error("zero length on slipping contact");

  // the pass counter restarts after the last contact of a pass
  a_pass_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last_in |=> (idx_r == '0))
    else $error("pass counter did not restart");

endmodule

@@ src/cfrc_div.sv @@
// ----------------------------------------------------------------------------
// cfrc_div
// Pipelined restoring divider, two lanes sharing one divisor. The caller
// hands in the top remainder (below the divisor) and the low dividend bits;
// each stage retires up to SPS quotient bits. A sideband word travels alongside.
// ----------------------------------------------------------------------------
module cfrc_div #(
  parameter int DW     = 32,
  parameter int QW     = 31,
  parameter int SPS    = 4,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [DW-1:0]          in_den,
  input  logic [1:0][DW-1:0]     in_rem,
  input  logic [1:0][QW-1:0]     in_lo,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0][QW-1:0]     out_quot,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int NS = (QW + SPS - 1) / SPS;

  logic [NS-1:0]          v_r;
  logic [NS-1:0]          v_src;
  logic [NS:0]            rdy;
  logic [DW-1:0]          den_r    [NS];
  logic [DW-1:0]          den_src  [NS];
  logic [1:0][DW-1:0]     rem_r    [NS];
  logic [1:0][DW-1:0]     rem_nxt  [NS];
  logic [1:0][QW-1:0]     lo_r     [NS];
  logic [1:0][QW-1:0]     lo_nxt   [NS];
  logic [SIDE_W-1:0]      side_r   [NS];
  logic [SIDE_W-1:0]      side_src [NS];

  // Stage moves when it is empty or the next one moves
  always_comb begin
    rdy[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  // Up to SPS restoring steps per stage; quotient bits shift in where dividend bits leave
  always_comb begin
    logic [DW:0] ext;
    ext = '0;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        v_src[s]    = in_valid;
        den_src[s]  = in_den;
        rem_nxt[s]  = in_rem;
        lo_nxt[s]   = in_lo;
        side_src[s] = in_side;
      end else begin
        v_src[s]    = v_r[s-1];
        den_src[s]  = den_r[s-1];
        rem_nxt[s]  = rem_r[s-1];
        lo_nxt[s]   = lo_r[s-1];
        side_src[s] = side_r[s-1];
      end
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < SPS; k++) begin
          if (s * SPS + k < QW) begin
            ext = {rem_nxt[s][l], lo_nxt[s][l][QW-1]};
            lo_nxt[s][l] = {lo_nxt[s][l][QW-2:0], 1'b0};
            if (ext >= {1'b0, den_src[s]}) begin
              ext = ext - {1'b0, den_src[s]};
              lo_nxt[s][l][0] = 1'b1;
            end
            rem_nxt[s][l] = ext[DW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rdy[s]) begin
        den_r[s]  <= den_src[s];
        rem_r[s]  <= rem_nxt[s];
        lo_r[s]   <= lo_nxt[s];
        side_r[s] <= side_src[s];
      end
    end
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) v_r[s] <= v_src[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_quot  = lo_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

@@ src/cfrc_sqrt.sv @@
// ----------------------------------------------------------------------------
// cfrc_sqrt
// Pipelined digit-by-digit integer square root (floor), SPS result bits per
// stage. A sideband word travels alongside.
// ----------------------------------------------------------------------------
module cfrc_sqrt #(
  parameter int XW     = 64,
  parameter int SPS    = 4,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [XW-1:0]       in_x,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [XW/2-1:0]     out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RW = XW / 2;
  localparam int NS = (RW + SPS - 1) / SPS;

  logic [NS-1:0]        v_r;
  logic [NS-1:0]        v_src;
  logic [NS:0]          rdy;
  logic [RW+1:0]        rem_r    [NS];
  logic [RW+1:0]        rem_nxt  [NS];
  logic [RW-1:0]        root_r   [NS];
  logic [RW-1:0]        root_nxt [NS];
  logic [XW-1:0]        xs_r     [NS];
  logic [XW-1:0]        xs_nxt   [NS];
  logic [SIDE_W-1:0]    side_r   [NS];
  logic [SIDE_W-1:0]    side_src [NS];

  always_comb begin
    rdy[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  // Bring down two radicand bits, try root*4+1
  always_comb begin
    logic [RW+1:0] r4;
    logic [RW+1:0] trial;
    r4 = '0;
    trial = '0;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        v_src[s]    = in_valid;
        rem_nxt[s]  = '0;
        root_nxt[s] = '0;
        xs_nxt[s]   = in_x;
        side_src[s] = in_side;
      end else begin
        v_src[s]    = v_r[s-1];
        rem_nxt[s]  = rem_r[s-1];
        root_nxt[s] = root_r[s-1];
        xs_nxt[s]   = xs_r[s-1];
        side_src[s] = side_r[s-1];
      end
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < RW) begin
          r4    = {rem_nxt[s][RW-1:0], xs_nxt[s][XW-1:XW-2]};
          trial = {root_nxt[s], 2'b01};
          xs_nxt[s] = {xs_nxt[s][XW-3:0], 2'b00};
          if (r4 >= trial) begin
            rem_nxt[s]  = r4 - trial;
            root_nxt[s] = {root_nxt[s][RW-2:0], 1'b1};
          end else begin
            rem_nxt[s]  = r4;
            root_nxt[s] = {root_nxt[s][RW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rdy[s]) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        xs_r[s]   <= xs_nxt[s];
        side_r[s] <= side_src[s];
      end
    end
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) v_r[s] <= v_src[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

@@ bench/coulomb_friction_impulse_clamp_unit_tb.sv @@
// ----------------------------------------------------------------------------
// coulomb_friction_impulse_clamp_unit_tb
// Self-checking bench for the friction impulse clamp. Contacts are driven over
// the in_ channel. A bit-accurate predictor works out each expected result
// when its input beat is accepted, and every out_ beat is compared against the
// oldest pending result. Covered: directed corner beats, pass counter
// behavior, random beats under several idle and stall mixes, a long receiver
// hold-off, and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module coulomb_friction_impulse_clamp_unit_tb;
  import cfrc_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;  // not a register, write is ignored
  localparam int PIPE_WAIT = 60;             // extra wait so the pipe settles after a drain
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic [31:0]        inverse_mass;
    logic signed [15:0] tan1_x, tan1_y, tan1_z;
    logic signed [15:0] tan2_x, tan2_y, tan2_z;
    logic [31:0]        normal_force;
    logic [15:0]        friction_coeff;
  } contact_t;

  typedef struct {
    logic [31:0] vel_x, vel_y, vel_z;
    logic        slipping;
    logic        last_contact;
  } velocity_update_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [31:0] in_vel_x, in_vel_y, in_vel_z;
  logic [31:0] in_inverse_mass;
  logic signed [15:0] in_tan1_x, in_tan1_y, in_tan1_z;
  logic signed [15:0] in_tan2_x, in_tan2_y, in_tan2_z;
  logic [31:0] in_normal_force;
  logic [15:0] in_friction_coeff;
  logic out_valid, out_ready;
  logic signed [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic out_slipping, out_last_contact;

  // predictor copy of registers and pass position
  logic [15:0] step_dt;
  logic [15:0] pass_len;
  logic [15:0] pass_pos;

  velocity_update_t pending_updates[$];
  int errors = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int contacts_sent = 0;
  int updates_seen = 0;
  int slips_seen = 0;
  int lasts_seen = 0;

  coulomb_friction_impulse_clamp_unit uut (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("coulomb_friction_impulse_clamp_unit_tb failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a counted hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // fixed-point helpers of the predictor
  // ---------------------------------------------------------------------------
  function automatic bit [63:0] magnitude(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint signed_of(bit [63:0] m, bit neg);
    longint r;
    r = longint'(m);
    return neg ? -r : r;
  endfunction

  // shift right, truncating toward zero
  function automatic longint shift_tz(longint x, int s);
    return signed_of(magnitude(x) >> s, x < 0);
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] r = 0;
    bit [63:0] b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // friction impulse and velocity update for one contact; advances pass_pos
  function automatic velocity_update_t friction_update(contact_t c);
    longint v[3], t1[3], t2[3], speed[2], imp[2];
    longint p, dv, nv;
    bit [63:0] minv, cone, sum, len, q;
    velocity_update_t u;
    v[0] = c.vel_x;  v[1] = c.vel_y;  v[2] = c.vel_z;
    t1[0] = c.tan1_x; t1[1] = c.tan1_y; t1[2] = c.tan1_z;
    t2[0] = c.tan2_x; t2[1] = c.tan2_y; t2[2] = c.tan2_z;
    minv = 64'(c.inverse_mass);
    speed[0] = shift_tz(v[0] * t1[0] + v[1] * t1[1] + v[2] * t1[2], 14);
    speed[1] = shift_tz(v[0] * t2[0] + v[1] * t2[1] + v[2] * t2[2], 14);
    for (int i = 0; i < 2; i++) begin
      if (minv == 0) begin
        imp[i] = 0;
      end else begin
        q = (magnitude(speed[i]) << 16) / minv;
        imp[i] = clip32(signed_of(q, speed[i] > 0));
      end
    end
    // friction cone radius
    cone = (((64'(step_dt) * 64'(c.normal_force)) >> 16) * 64'(c.friction_coeff)) >> 14;
    if (cone > 64'h7FFF_FFFF) cone = 64'h7FFF_FFFF;
    sum = magnitude(imp[0]) * magnitude(imp[0]) + magnitude(imp[1]) * magnitude(imp[1]);
    u.slipping = 1'b0;
    if (sum > cone * cone) begin
      len = floor_sqrt(sum);
      if (len == 0) len = 1;
      u.slipping = 1'b1;
      for (int i = 0; i < 2; i++)
        imp[i] = signed_of(magnitude(imp[i]) * cone / len, imp[i] < 0);
    end
    // apply impulse per axis
    for (int i = 0; i < 3; i++) begin
      p = clip32(shift_tz(imp[0] * t1[i] + imp[1] * t2[i], 14));
      dv = signed_of((minv * magnitude(p)) >> 16, p < 0);
      nv = clip32(v[i] + dv);
      if (i == 0) u.vel_x = nv[31:0];
      else if (i == 1) u.vel_y = nv[31:0];
      else u.vel_z = nv[31:0];
    end
    // pass counter
    if (pass_len != 0 && 17'(pass_pos) + 17'd1 >= 17'(pass_len)) begin
      u.last_contact = 1'b1;
      pass_pos = 16'd0;
    end else begin
      u.last_contact = 1'b0;
      pass_pos = pass_pos + 16'd1;
    end
    return u;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    velocity_update_t e;
    if (rst_n && out_valid && out_ready) begin
      updates_seen++;
      if (out_slipping) slips_seen++;
      if (out_last_contact) lasts_seen++;
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result beat, actual vel %h %h %h", $time,
                 out_new_vel_x, out_new_vel_y, out_new_vel_z);
        errors++;
      end else begin
        e = pending_updates.pop_front();
        if (out_new_vel_x !== e.vel_x) begin
          $display("%0t: new_vel_x expected %h actual %h", $time, e.vel_x, out_new_vel_x);
          errors++;
        end
        if (out_new_vel_y !== e.vel_y) begin
          $display("%0t: new_vel_y expected %h actual %h", $time, e.vel_y, out_new_vel_y);
          errors++;
        end
        if (out_new_vel_z !== e.vel_z) begin
          $display("%0t: new_vel_z expected %h actual %h", $time, e.vel_z, out_new_vel_z);
          errors++;
        end
        if (out_slipping !== e.slipping) begin
          $display("%0t: slipping expected %b actual %b", $time, e.slipping, out_slipping);
          errors++;
        end
        if (out_last_contact !== e.last_contact) begin
          $display("%0t: last_contact expected %b actual %b", $time, e.last_contact,
                   out_last_contact);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks, all entered just after a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_contact(contact_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vel_x <= c.vel_x;
    in_vel_y <= c.vel_y;
    in_vel_z <= c.vel_z;
    in_inverse_mass <= c.inverse_mass;
    in_tan1_x <= c.tan1_x;
    in_tan1_y <= c.tan1_y;
    in_tan1_z <= c.tan1_z;
    in_tan2_x <= c.tan2_x;
    in_tan2_y <= c.tan2_y;
    in_tan2_z <= c.tan2_z;
    in_normal_force <= c.normal_force;
    in_friction_coeff <= c.friction_coeff;
    do @(posedge clk); while (!in_ready);
    pending_updates.push_back(friction_update(c));
    contacts_sent++;
  endtask

  // lower valid, wait for every pending result, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIME_STEP) step_dt = val;
    else if (idx == REG_CONTACT_COUNT) pass_len = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word(int scale);
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(scale);
      2: return -$urandom_range(scale);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_tangent();
    return $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(32768) - 16384);
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    c.vel_x = rand_word(32'h0040_0000);
    c.vel_y = rand_word(32'h0040_0000);
    c.vel_z = rand_word(32'h0040_0000);
    case ($urandom_range(5))
      0: c.inverse_mass = 32'd0;
      1: c.inverse_mass = $urandom;
      default: c.inverse_mass = $urandom_range(32'h0004_0000, 1);
    endcase
    c.tan1_x = rand_tangent(); c.tan1_y = rand_tangent(); c.tan1_z = rand_tangent();
    c.tan2_x = rand_tangent(); c.tan2_y = rand_tangent(); c.tan2_z = rand_tangent();
    c.normal_force = $urandom_range(1) ? $urandom : $urandom_range(32'h0100_0000);
    c.friction_coeff = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(16384));
    return c;
  endfunction

  function automatic contact_t uniform_contact(logic [31:0] v, logic [31:0] m,
                                                logic [15:0] t, logic [31:0] nf,
                                                logic [15:0] mu);
    contact_t c;
    c.vel_x = v; c.vel_y = -v; c.vel_z = v;
    c.inverse_mass = m;
    c.tan1_x = t; c.tan1_y = 16'd0; c.tan1_z = -t;
    c.tan2_x = 16'd0; c.tan2_y = t; c.tan2_z = t;
    c.normal_force = nf;
    c.friction_coeff = mu;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    contact_t c;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    // static particle: velocity passes through
    send_contact(uniform_contact(32'h0001_0000, 32'd0, 16'h4000, 32'hFFFF_FFFF, 16'hFFFF));
    send_contact(uniform_contact(32'h7FFF_FFFF, 32'd0, 16'h8000, 32'd0, 16'd0));
    // extremes of every field
    send_contact(uniform_contact(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 32'hFFFF_FFFF,
                                 16'hFFFF));
    send_contact(uniform_contact(32'h8000_0000, 32'hFFFF_FFFF, 16'h8000, 32'hFFFF_FFFF,
                                 16'hFFFF));
    send_contact(uniform_contact(32'h8000_0000, 32'd1, 16'h8000, 32'd0, 16'd0));
    send_contact(uniform_contact(32'h7FFF_FFFF, 32'd1, 16'h7FFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_contact(uniform_contact(32'd0, 32'h0001_0000, 16'h4000, 32'hFFFF_FFFF, 16'hFFFF));
    send_contact(uniform_contact(32'hFFFF_FFFF, 32'd1, 16'hFFFF, 32'd1, 16'd1));
    // sticking versus slipping with unit mass and unit tangents
    send_contact(uniform_contact(32'h0000_1000, 32'h0001_0000, 16'h4000, 32'h0100_0000,
                                 16'h4000));
    send_contact(uniform_contact(32'h0010_0000, 32'h0001_0000, 16'h4000, 32'h0001_0000,
                                 16'h0800));
    send_contact(uniform_contact(32'h0010_0000, 32'h0001_0000, 16'h4000, 32'h0001_0000,
                                 16'd0));
    // all ones and all zeros
    c = uniform_contact(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    c.vel_y = 32'hFFFF_FFFF; c.tan1_y = 16'hFFFF; c.tan2_x = 16'hFFFF;
    send_contact(c);
    send_contact(uniform_contact(32'd0, 32'd0, 16'd0, 32'd0, 16'd0));
    drain();
  endtask

  task automatic test_pass_counter();
    write_reg(REG_CONTACT_COUNT, 16'd1);
    repeat (4) send_contact(rand_contact());
    drain();
    write_reg(REG_CONTACT_COUNT, 16'd5);
    repeat (12) send_contact(rand_contact());
    drain();
    // count lowered mid pass: next beat closes the pass at once
    write_reg(REG_CONTACT_COUNT, 16'd2);
    repeat (5) send_contact(rand_contact());
    drain();
    write_reg(REG_CONTACT_COUNT, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h0003);
    repeat (6) send_contact(rand_contact());
    drain();
    write_reg(REG_CONTACT_COUNT, 16'd0);
    repeat (6) send_contact(rand_contact());
    drain();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, logic [15:0] dt,
                                   logic [15:0] count, int n);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_CONTACT_COUNT, count);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n) send_contact(rand_contact());
    drain();
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills
  task automatic test_backpressure();
    write_reg(REG_TIME_STEP, 16'd1092);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_cycles = 200;
    repeat (80) send_contact(rand_contact());
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_TIME_STEP;
    cfg_data <= 16'd0;
    in_valid <= 1'b0;
    in_vel_x <= '0; in_vel_y <= '0; in_vel_z <= '0;
    in_inverse_mass <= '0;
    in_tan1_x <= '0; in_tan1_y <= '0; in_tan1_z <= '0;
    in_tan2_x <= '0; in_tan2_y <= '0; in_tan2_z <= '0;
    in_normal_force <= '0;
    in_friction_coeff <= '0;
    out_ready <= 1'b0;
    step_dt = TIME_STEP_RST;
    pass_len = 16'd0;
    pass_pos = 16'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pass_counter();
    test_random_phase(0, 0, 16'd1092, 16'd7, 230);
    test_random_phase(71, 0, 16'hFFFF, 16'd3, 230);
    test_random_phase(0, 71, 16'd0, 16'd64, 230);
    test_random_phase(18, 18, 16'd1, 16'd1, 230);
    test_backpressure();

    $display("%0d contacts sent, %0d results checked, %0d slipping, %0d pass ends",
             contacts_sent, updates_seen, slips_seen, lasts_seen);
    $display("covered corner beats, pass counter changes, idle/stall mixes, backpressure");
    if (errors == 0 && pending_updates.size() == 0) begin
      $display("coulomb_friction_impulse_clamp_unit_tb passed");
    end else begin
      $display("coulomb_friction_impulse_clamp_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/cfrc_pkg.sv
src/cfrc_div.sv
src/cfrc_sqrt.sv
src/coulomb_friction_impulse_clamp_unit.sv
bench/coulomb_friction_impulse_clamp_unit_tb.sv
